// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, masked while reset is asserted
`define GMC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("gmc assertion failed");

// implication form of the same check
`define GMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	`GMC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ===== rtl/gmc_pkg.sv =====
// ----------------------------------------------------------------------------
// gmc_pkg
// shared widths, types and register codes of the meiosis crossover block
// ----------------------------------------------------------------------------
`default_nettype none

package gmc_pkg;

	localparam int MAX_LOCI     = 1024;
	localparam int MAX_CHROMO   = 64;
	localparam int LOCUS_W      = $clog2(MAX_LOCI);
	localparam int CHROMO_W     = $clog2(MAX_CHROMO);
	localparam int RATE_W       = 17;
	localparam int DRAW_W       = 16;
	localparam int GENO_W       = 2;
	localparam int LOCI_REG_W   = 11;
	localparam int CHROMO_REG_W = 7;
	localparam int CFG_DATA_W   = 17;
	localparam int CFG_IDX_W    = 3;
	localparam int IN_TDATA_W   = 40;
	localparam int OUT_TDATA_W  = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEFAULT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_BOTH_HET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MISSEG_PROB   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCI          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHROMO    = 3'd4;

	// register reset values
	localparam logic [RATE_W-1:0]       RST_RATE_DEFAULT  = 17'd3736;
	localparam logic [RATE_W-1:0]       RST_RATE_BOTH_HET = 17'd37;
	localparam logic [RATE_W-1:0]       RST_MISSEG_PROB   = 17'd29491;
	localparam logic [LOCI_REG_W-1:0]   RST_LOCI          = 11'd200;
	localparam logic [CHROMO_REG_W-1:0] RST_NUM_CHROMO    = 7'd16;

	typedef struct packed {
		logic [GENO_W-1:0] genotype;
		logic [DRAW_W-1:0] cross_draw;
		logic              strand_draw;
		logic [DRAW_W-1:0] misseg_draw;
	} in_beat_t;

	typedef struct packed {
		logic allele;
		logic allele_valid;
		logic last_locus;
		logic viable;
	} result_t;

	typedef struct packed {
		logic                strand;
		logic [GENO_W-1:0]   prev_genotype;
		logic                crossed_flag;
		logic [LOCUS_W-1:0]  locus_count;
		logic [CHROMO_W-1:0] chromo_count;
		logic                dead_flag;
	} state_t;

	// live configuration, lengths already clamped to last indexes
	typedef struct packed {
		logic [RATE_W-1:0]   rate_default;
		logic [RATE_W-1:0]   rate_both_het;
		logic [RATE_W-1:0]   misseg_prob;
		logic [LOCUS_W-1:0]  loci_last;
		logic [CHROMO_W-1:0] chromo_last;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/gmc_cfg.sv =====
// ----------------------------------------------------------------------------
// gmc_cfg
// configuration registers with length clamping
// ----------------------------------------------------------------------------
`default_nettype none

module gmc_cfg
	import gmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [RATE_W-1:0]       rate_default_q;
	logic [RATE_W-1:0]       rate_both_het_q;
	logic [RATE_W-1:0]       misseg_prob_q;
	logic [LOCI_REG_W-1:0]   loci_q;
	logic [CHROMO_REG_W-1:0] num_chromo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_default_q  <= RST_RATE_DEFAULT;
			rate_both_het_q <= RST_RATE_BOTH_HET;
			misseg_prob_q   <= RST_MISSEG_PROB;
			loci_q          <= RST_LOCI;
			num_chromo_q    <= RST_NUM_CHROMO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RATE_DEFAULT:  rate_default_q  <= cfg_data[RATE_W-1:0];
				CFG_RATE_BOTH_HET: rate_both_het_q <= cfg_data[RATE_W-1:0];
				CFG_MISSEG_PROB:   misseg_prob_q   <= cfg_data[RATE_W-1:0];
				CFG_LOCI:          loci_q          <= cfg_data[LOCI_REG_W-1:0];
				CFG_NUM_CHROMO:    num_chromo_q    <= cfg_data[CHROMO_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, large values saturate at the limit
	always_comb begin
		cfg.rate_default  = rate_default_q;
		cfg.rate_both_het = rate_both_het_q;
		cfg.misseg_prob   = misseg_prob_q;
		priority if (loci_q == '0)
			cfg.loci_last = '0;
		else if (loci_q > LOCI_REG_W'(MAX_LOCI))
			cfg.loci_last = LOCUS_W'(MAX_LOCI - 1);
		else
			cfg.loci_last = LOCUS_W'(loci_q - LOCI_REG_W'(1));
		priority if (num_chromo_q == '0)
			cfg.chromo_last = '0;
		else if (num_chromo_q > CHROMO_REG_W'(MAX_CHROMO))
			cfg.chromo_last = CHROMO_W'(MAX_CHROMO - 1);
		else
			cfg.chromo_last = CHROMO_W'(num_chromo_q - CHROMO_REG_W'(1));
	end

endmodule

`default_nettype wire

// ===== rtl/gmc_step.sv =====
// ----------------------------------------------------------------------------
// gmc_step
// per-locus strand choice, crossover and mis-segregation logic
// ----------------------------------------------------------------------------
`default_nettype none

module gmc_step
	import gmc_pkg::*;
(
	input  cfg_t     cfg,
	input  state_t   cur,
	input  in_beat_t beat,
	output state_t   nxt,
	output result_t  res
);

	logic              first_locus;
	logic              het_prev;
	logic              het_cur;
	logic [RATE_W-1:0] rate;
	logic              hit;
	logic              strand_n;
	logic              crossed_n;
	logic              dead_n;
	logic              end_chromo;
	logic              end_genome;
	logic              allele;

	always_comb begin
		first_locus = (cur.locus_count == '0);
		het_prev    = cur.prev_genotype[1] ^ cur.prev_genotype[0];
		het_cur     = beat.genotype[1] ^ beat.genotype[0];
		rate        = (het_prev && het_cur) ? cfg.rate_both_het : cfg.rate_default;
		hit         = ({1'b0, beat.cross_draw} < rate);

		if (first_locus) begin
			strand_n  = beat.strand_draw;
			crossed_n = 1'b0;
		end else begin
			strand_n  = cur.strand ^ hit;
			crossed_n = cur.crossed_flag | hit;
		end
		allele = strand_n ? beat.genotype[1] : beat.genotype[0];

		end_chromo = (cur.locus_count >= cfg.loci_last);
		end_genome = end_chromo && (cur.chromo_count >= cfg.chromo_last);
		dead_n     = cur.dead_flag |
			(end_chromo && !crossed_n && ({1'b0, beat.misseg_draw} < cfg.misseg_prob));

		res.allele       = allele & ~cur.dead_flag;
		res.allele_valid = ~cur.dead_flag;
		res.last_locus   = end_genome;
		res.viable       = end_genome & ~dead_n;

		priority if (end_genome) begin
			nxt = '0;
		end else if (end_chromo) begin
			nxt.strand        = strand_n;
			nxt.prev_genotype = beat.genotype;
			nxt.crossed_flag  = crossed_n;
			nxt.locus_count   = '0;
			nxt.chromo_count  = cur.chromo_count + CHROMO_W'(1);
			nxt.dead_flag     = dead_n;
		end else begin
			nxt.strand        = strand_n;
			nxt.prev_genotype = beat.genotype;
			nxt.crossed_flag  = crossed_n;
			nxt.locus_count   = cur.locus_count + LOCUS_W'(1);
			nxt.chromo_count  = cur.chromo_count;
			nxt.dead_flag     = dead_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gamete_meiosis_crossover_core.sv =====
// ----------------------------------------------------------------------------
// gamete_meiosis_crossover_core
// forms one haploid gamete from a diploid genotype stream, one locus a beat
// ----------------------------------------------------------------------------
// usage:
//   slave stream s_*: one beat per locus, loci in chromosome order, each beat
//     carrying the genotype and the random draws used at that locus
//   master stream m_*: one beat per accepted locus with the passed allele,
//     its valid flag and the viable flag; m_tlast marks the final locus of
//     the final chromosome, i.e. the end of one gamete
//   cfg_*: write-only registers, written while the block is idle
// path: an accepted locus passes the input register, then the result register, to m_*
// throughput: one locus per cycle while the output is not stalled; the only loop is
//   the strand, count and flag state fed back through the single step stage per locus
// stalls: an input register and an output register decouple the sides; when
//   m_tready is low the result holds, the input register fills and s_tready
//   drops while that register is full and the output stays blocked
// reset: arst_n clears both stage valids, the gamete state and restores the
//   register defaults; the next beat starts a fresh gamete
// ----------------------------------------------------------------------------
`default_nettype none

module gamete_meiosis_crossover_core
	import gmc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// config write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// genotype[1:0], cross_draw[17:2], strand_draw[18], misseg_draw[34:19], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// allele[0], allele_valid[1], viable[2], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	cfg_t     cfg;
	in_beat_t in_s1;
	logic     in_valid_s1;
	state_t   state_q;
	state_t   state_nxt;
	result_t  res;
	result_t  out_q;
	logic     out_valid_q;
	logic     out_free;
	logic     advance;
	logic     in_take;

	gmc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// output slot free when empty or being drained this cycle
	assign out_free = !out_valid_q || m_tready;
	assign advance  = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_take) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			in_s1.genotype    <= s_tdata[1:0];
			in_s1.cross_draw  <= s_tdata[17:2];
			in_s1.strand_draw <= s_tdata[18];
			in_s1.misseg_draw <= s_tdata[34:19];
		end
	end

	// one locus of work between the two registers
	gmc_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.beat (in_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	// gamete state only moves when a locus is committed to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.viable, out_q.allele_valid, out_q.allele};
	assign m_tlast  = out_q.last_locus;

endmodule

`default_nettype wire

// ===== rtl/gmc_checker.sv =====
// ----------------------------------------------------------------------------
// gmc_checker
// port-level checks of the crossover core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gmc_checker
	import gmc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast
);

	// a stalled result beat holds
	`GMC_ASSERT(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))

	// viable is only reported on the final locus
	`GMC_ASSERT_IMP(a_viable_last, clk, arst_n, m_tvalid && !m_tlast, !m_tdata[2])

	// a dead gamete passes a zero allele
	`GMC_ASSERT_IMP(a_dead_zero, clk, arst_n, m_tvalid && !m_tdata[1], !m_tdata[0])

	// a viable gamete is still alive on its final locus
	`GMC_ASSERT_IMP(a_viable_alive, clk, arst_n, m_tvalid && m_tlast && m_tdata[2], m_tdata[1])

endmodule

bind gamete_meiosis_crossover_core gmc_checker u_gmc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
